>>> design/bmmd_pkg.sv
// shared types and constants for the banked memory map decoder
`timescale 1ns / 1ps
package bmmd_pkg;

  // field widths
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned REGION_W    = 3;
  localparam int unsigned EXT_W       = 21;
  localparam int unsigned MAP_W       = 2;
  localparam int unsigned RAM_BANK_W  = 2;
  localparam int unsigned BANK_MAX_W  = 7;

  // parameter defaults
  localparam int unsigned IO_DEPTH_DEFAULT      = 76;
  localparam int unsigned ROM_BANK_BITS_DEFAULT = 7;

  // fixed store sizes
  localparam int unsigned OAM_DEPTH = 160;

  // mapper types
  localparam logic [MAP_W-1:0] MAP_NONE = 2'd0;
  localparam logic [MAP_W-1:0] MAP_MBC1 = 2'd1;
  localparam logic [MAP_W-1:0] MAP_MBC3 = 2'd2;

  // region codes
  localparam logic [REGION_W-1:0] REGION_INTERNAL = 3'd0;
  localparam logic [REGION_W-1:0] REGION_BOOT     = 3'd1;
  localparam logic [REGION_W-1:0] REGION_ROM      = 3'd2;
  localparam logic [REGION_W-1:0] REGION_CART_RAM = 3'd3;
  localparam logic [REGION_W-1:0] REGION_UNMAPPED = 3'd4;
  localparam logic [REGION_W-1:0] REGION_MAPPER   = 3'd5;

  // mapper register windows, selected by address bits 14..13
  localparam logic [1:0] MBC_WIN_ENABLE = 2'd0;
  localparam logic [1:0] MBC_WIN_BANK   = 2'd1;
  localparam logic [1:0] MBC_WIN_UPPER  = 2'd2;
  localparam logic [1:0] MBC_WIN_MODE   = 2'd3;

  localparam logic [DATA_W-1:0] RAM_ENABLE_KEY = 8'h0A;
  localparam logic [DATA_W-1:0] UNMAPPED_BYTE  = 8'hFF;

  // bus map
  localparam logic [ADDR_W-1:0] ADDR_BOOT_END = 16'h0100;
  localparam logic [ADDR_W-1:0] ADDR_ROMX     = 16'h4000;
  localparam logic [ADDR_W-1:0] ADDR_VRAM     = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_CART_RAM = 16'hA000;
  localparam logic [ADDR_W-1:0] ADDR_WRAM     = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_OAM      = 16'hFE00;
  localparam logic [ADDR_W-1:0] ADDR_OAM_END  = ADDR_W'(16'hFE00 + OAM_DEPTH);
  localparam logic [ADDR_W-1:0] ADDR_IO       = 16'hFF00;
  localparam logic [ADDR_W-1:0] ADDR_HRAM     = 16'hFF80;
  localparam logic [ADDR_W-1:0] ADDR_IE       = 16'hFFFF;

  // layout of the shared internal store
  localparam int unsigned MEM_ADDR_W = 15;
  localparam logic [MEM_ADDR_W-1:0] MEM_VRAM_BASE = 15'h0000;
  localparam logic [MEM_ADDR_W-1:0] MEM_WRAM_BASE = 15'h2000;
  localparam logic [MEM_ADDR_W-1:0] MEM_OAM_BASE  = 15'h4000;
  localparam logic [MEM_ADDR_W-1:0] MEM_IO_BASE   = 15'h4100;
  localparam logic [MEM_ADDR_W-1:0] MEM_HRAM_BASE = 15'h4180;
  localparam logic [MEM_ADDR_W-1:0] MEM_IE_ADDR   = 15'h4200;
  localparam int unsigned STORE_DEPTH = 32'h4201;

  typedef struct packed {
    logic              is_write;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic [REGION_W-1:0] region;
    logic [EXT_W-1:0]    external_address;
    logic                external_write;
    logic                ram_enabled;
  } rsp_t;

  typedef struct packed {
    logic [MAP_W-1:0] mapper_type;
  } cfg_t;

endpackage

>>> design/bmmd_chan_if.sv
// valid/ready channel carrying one payload item
`timescale 1ns / 1ps
interface bmmd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> design/banked_memory_map_decoder_top.sv
// top level of the banked memory map decoder with cartridge mapper
`timescale 1ns / 1ps
// Decodes one CPU bus access per item against the 64K map and answers with
// one result item: the byte read from an internal store (video, work with its
// echo, sprite, I/O, high RAM and the interrupt-enable byte), 0xFF for
// unmapped reads, or a region code with a translated external address for
// boot ROM, cartridge ROM and cartridge RAM. Writes below 0x8000 program the
// MBC1 or MBC3 bank registers chosen by the mapper_type register. All internal
// stores share one single-port synchronous memory, touched once per item, so
// the block takes one item per cycle unless the output stalls, through a
// memory read stage and then an output register. After reset a clearing
// pass zeroes all 16897 store entries, one entry a cycle; req.ready stays
// low during it while the configuration port keeps taking writes. The user
// must write configuration only while the block is idle; it is not enforced.
module banked_memory_map_decoder_top #(
  parameter int unsigned IO_DEPTH      = bmmd_pkg::IO_DEPTH_DEFAULT,
  parameter int unsigned ROM_BANK_BITS = bmmd_pkg::ROM_BANK_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  bmmd_chan_if.sink   req,
  bmmd_chan_if.source rsp,
  bmmd_chan_if.sink   cfg
);
  import bmmd_pkg::*;

  // mapper and boot state
  logic [MAP_W-1:0]         mapper_type;
  logic [ROM_BANK_BITS-1:0] rom_page, rom_page_next;
  logic [RAM_BANK_W-1:0]    ram_page, ram_page_next;
  logic                     banking_mode, banking_mode_next;
  logic                     cart_ram_enable, cart_ram_enable_next;
  logic                     boot_active, boot_active_next;

  // shared internal store and its clearing pass
  logic [DATA_W-1:0]     mem [STORE_DEPTH];
  logic [DATA_W-1:0]     mem_rdata;
  logic                  clearing;
  logic [MEM_ADDR_W-1:0] clr_addr;

  // memory stage and output register
  logic                s1_valid;
  logic                s1_from_mem;
  logic                s1_unmapped_rd;
  logic [REGION_W-1:0] s1_region;
  logic [EXT_W-1:0]    s1_ext;
  logic                s1_xw;
  logic                s1_ram_en;
  logic                s1_advance;
  logic                acc;

  // decode of the incoming access
  logic                wr;
  logic [ADDR_W-1:0]   a;
  logic [DATA_W-1:0]   wdata;
  logic                hit;
  logic                io_ok;
  logic [REGION_W-1:0] region;
  logic [EXT_W-1:0]    ext;
  logic [MEM_ADDR_W-1:0] mem_addr;

  // mapper write scratch
  logic [BANK_MAX_W-1:0] bank_wide;
  logic [BANK_MAX_W-1:0] bank_new;
  logic [4:0]            low5;

  assign wr    = req.payload.is_write;
  assign a     = req.payload.address;
  assign wdata = req.payload.write_data;

  // handshakes: the memory stage moves on when the output register frees up
  assign s1_advance = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready  = !clearing && (!s1_valid || s1_advance);
  assign acc        = req.valid && req.ready;
  assign cfg.ready  = 1'b1;

  // io window size follows the parameter; the gap above it reads as unmapped
  assign io_ok = ({1'b0, a[7:0]} < 9'(IO_DEPTH));

  // address decode
  always_comb begin
    hit      = 1'b0;
    region   = REGION_INTERNAL;
    ext      = '0;
    mem_addr = '0;
    priority if (a < ADDR_VRAM) begin
      if (wr) begin
        region = REGION_MAPPER;
      end else if (a < ADDR_ROMX) begin
        region = (boot_active && a < ADDR_BOOT_END) ? REGION_BOOT : REGION_ROM;
        ext    = EXT_W'(a);
      end else begin
        region = REGION_ROM;
        ext    = (EXT_W'(rom_page) << 14) | EXT_W'(a[13:0]);
      end
    end else if (a < ADDR_CART_RAM) begin
      hit      = 1'b1;
      mem_addr = MEM_VRAM_BASE | MEM_ADDR_W'(a[12:0]);
    end else if (a < ADDR_WRAM) begin
      region = REGION_CART_RAM;
      ext    = (EXT_W'(ram_page) << 13) | EXT_W'(a[12:0]);
    end else if (a < ADDR_OAM) begin
      // work ram and its echo share an index
      hit      = 1'b1;
      mem_addr = MEM_WRAM_BASE | MEM_ADDR_W'(a[12:0]);
    end else if (a < ADDR_OAM_END) begin
      hit      = 1'b1;
      mem_addr = MEM_OAM_BASE | MEM_ADDR_W'(a[7:0]);
    end else if (a < ADDR_IO) begin
      region = REGION_UNMAPPED;
    end else if (a < ADDR_HRAM && io_ok) begin
      hit      = 1'b1;
      mem_addr = MEM_IO_BASE | MEM_ADDR_W'(a[6:0]);
    end else if (a < ADDR_HRAM) begin
      region = REGION_UNMAPPED;
    end else if (a < ADDR_IE) begin
      hit      = 1'b1;
      mem_addr = MEM_HRAM_BASE | MEM_ADDR_W'(a[6:0]);
    end else begin
      hit      = 1'b1;
      mem_addr = MEM_IE_ADDR;
    end
  end

  // mapper register updates and boot exit
  always_comb begin
    rom_page_next        = rom_page;
    ram_page_next        = ram_page;
    banking_mode_next    = banking_mode;
    cart_ram_enable_next = cart_ram_enable;
    boot_active_next     = boot_active;
    bank_wide            = BANK_MAX_W'(rom_page);
    bank_new             = bank_wide;
    low5                 = wdata[4:0];
    if (acc && !wr && a == ADDR_BOOT_END) begin
      boot_active_next = 1'b0;
    end
    if (acc && wr && a < ADDR_VRAM) begin
      unique case (mapper_type)
        MAP_MBC1: begin
          unique case (a[14:13])
            MBC_WIN_ENABLE: cart_ram_enable_next = (wdata == RAM_ENABLE_KEY);
            MBC_WIN_BANK: begin
              // zero low bank bits select bank one
              if (wdata[4:0] == '0) low5 = 5'd1;
              bank_new      = {bank_wide[6:5], low5};
              rom_page_next = bank_new[ROM_BANK_BITS-1:0];
            end
            MBC_WIN_UPPER: begin
              if (banking_mode) begin
                ram_page_next = wdata[1:0];
              end else begin
                bank_new      = {wdata[1:0], bank_wide[4:0]};
                rom_page_next = bank_new[ROM_BANK_BITS-1:0];
              end
            end
            MBC_WIN_MODE: banking_mode_next = wdata[0];
          endcase
        end
        MAP_MBC3: begin
          unique case (a[14:13])
            MBC_WIN_ENABLE: cart_ram_enable_next = (wdata == RAM_ENABLE_KEY);
            MBC_WIN_BANK: begin
              bank_new = wdata[6:0];
              if (wdata[6:0] == '0) bank_new = BANK_MAX_W'(1);
              rom_page_next = bank_new[ROM_BANK_BITS-1:0];
            end
            MBC_WIN_UPPER: begin
              // values of four and up leave the ram bank as it is
              if (wdata < 8'd4) ram_page_next = wdata[1:0];
            end
            MBC_WIN_MODE: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_type     <= MAP_NONE;
      rom_page        <= ROM_BANK_BITS'(1);
      ram_page        <= '0;
      banking_mode    <= 1'b0;
      cart_ram_enable <= 1'b0;
      boot_active     <= 1'b1;
      clearing        <= 1'b1;
      clr_addr        <= '0;
      s1_valid        <= 1'b0;
      rsp.valid       <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) mapper_type <= cfg.payload.mapper_type;
      rom_page        <= rom_page_next;
      ram_page        <= ram_page_next;
      banking_mode    <= banking_mode_next;
      cart_ram_enable <= cart_ram_enable_next;
      boot_active     <= boot_active_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == MEM_ADDR_W'(STORE_DEPTH - 1)) clearing <= 1'b0;
      end
      if (acc) s1_valid <= 1'b1;
      else if (s1_advance) s1_valid <= 1'b0;
      if (s1_advance) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  // shared store: clearing pass, else a read per accepted item and a write for internal writes
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (acc && hit && wr) begin
      mem[mem_addr] <= wdata;
    end
    if (acc) mem_rdata <= mem[mem_addr];
  end

  // memory stage payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_from_mem    <= hit && !wr;
      s1_unmapped_rd <= (region == REGION_UNMAPPED) && !wr;
      s1_region      <= region;
      s1_ext         <= ext;
      s1_xw          <= (region == REGION_CART_RAM) && wr;
      s1_ram_en      <= cart_ram_enable_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      rsp.payload.read_data        <= s1_from_mem ? mem_rdata :
                                      (s1_unmapped_rd ? UNMAPPED_BYTE : '0);
      rsp.payload.region           <= s1_region;
      rsp.payload.external_address <= s1_ext;
      rsp.payload.external_write   <= s1_xw;
      rsp.payload.ram_enabled      <= s1_ram_en;
    end
  end

`ifndef ASSERT_OFF
  // no bus item is taken while the store is being cleared
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("item accepted during clearing pass");

  // a full pipe with a stalled output must hold off the bus
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && rsp.valid && !rsp.ready) |-> !req.ready)
    else $error("item accepted while pipe is blocked");

  // the boot phase never comes back without reset
  a_boot_stays_off: assert property (@(posedge clk) disable iff (rst)
    !boot_active |=> !boot_active)
    else $error("boot flag set again after exit");

  // only cartridge ram accesses drive the external write strobe
  a_ext_write_region: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.external_write) |->
      (rsp.payload.region == REGION_CART_RAM))
    else $error("external write outside cartridge ram");
`endif

endmodule
